// ----- hdl/nested_scope_time_accumulator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef NESTED_SCOPE_TIME_ACCUMULATOR_DEFINES_SVH
`define NESTED_SCOPE_TIME_ACCUMULATOR_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define NSTA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsta assertion failed");

// Check a consequence in the cycle after its antecedent.
`define NSTA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsta assertion failed");

`endif

// ----- hdl/nsta_pkg.sv -----
`default_nettype none
package nsta_pkg;

   localparam int TIME_BITS   = 48;
   localparam int ANCHOR_BITS = 8;
   localparam int CALL_BITS   = 32;
   localparam int LIMIT_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_EXIT  = 2'd1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACE_LIMIT  = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_ANCHOR = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_TOTALS,
      ST_POP,
      ST_ACC,
      ST_PARENT_RD,
      ST_PARENT_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] exclusive;
      logic [TIME_BITS-1:0] inclusive;
      logic [CALL_BITS-1:0] calls;
   } totals_type;

   typedef struct packed {
      logic [ANCHOR_BITS-1:0] anchor;
      logic [TIME_BITS-1:0]   start;
   } frame_type;

   typedef struct packed {
      logic ready;
      logic clear_step;
      logic take_item;
      logic fail_anchor;
      logic fail_empty;
      logic read_issue;
      logic capture_totals;
      logic pop_issue;
      logic pop_capture;
      logic acc_update;
      logic parent_issue;
      logic parent_update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic op_exit;
      logic anchor_bad;
      logic depth_zero;
      logic clear_last;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

// ----- hdl/nsta_ctrl.sv -----
`default_nettype none
module nsta_ctrl
   import nsta_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (stat.op_exit && stat.depth_zero) begin
               cmd.fail_empty = 1'b1;
               state_in       = ST_RESP;
            end else if (stat.op_exit) begin
               cmd.pop_issue = 1'b1;
               state_in      = ST_POP;
            end else if (stat.anchor_bad) begin
               cmd.fail_anchor = 1'b1;
               state_in        = ST_RESP;
            end else begin
               cmd.read_issue = 1'b1;
               state_in       = ST_TOTALS;
            end
         end
         ST_TOTALS: begin
            cmd.capture_totals = 1'b1;
            state_in           = ST_RESP;
         end
         ST_POP: begin
            cmd.pop_capture = 1'b1;
            state_in        = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_update = 1'b1;
            state_in       = stat.depth_zero ? ST_RESP : ST_PARENT_RD;
         end
         ST_PARENT_RD: begin
            cmd.parent_issue = 1'b1;
            state_in         = ST_PARENT_WR;
         end
         ST_PARENT_WR: begin
            cmd.parent_update = 1'b1;
            state_in          = ST_RESP;
         end
         ST_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/nsta_datapath.sv -----
`default_nettype none
module nsta_datapath
   import nsta_pkg::*;
#(
   parameter int ANCHORS    = 256,
   parameter int NEST_DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output stat_type                       stat,
   input  wire logic [1:0]                req_operation,
   input  wire logic [ANCHOR_BITS-1:0]    req_anchor,
   input  wire logic [TIME_BITS-1:0]      req_timestamp,
   input  wire logic                      csr_valid,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [LIMIT_BITS-1:0]     csr_wdata,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [ANCHOR_BITS-1:0]         rsp_result_anchor,
   output logic [TIME_BITS-1:0]           rsp_exclusive_total,
   output logic [TIME_BITS-1:0]           rsp_inclusive_total,
   output logic [CALL_BITS-1:0]           rsp_call_count,
   output logic                           rsp_trace_valid,
   output logic [TIME_BITS-1:0]           rsp_trace_start,
   output logic [TIME_BITS-1:0]           rsp_trace_duration
);

   localparam int AW = $clog2(ANCHORS);
   localparam int EW = (AW > ANCHOR_BITS) ? AW : ANCHOR_BITS;
   localparam int SW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int DW = $clog2(NEST_DEPTH + 1);

   // configuration
   logic                  trace_en_ff;
   logic [LIMIT_BITS-1:0] trace_limit_ff;
   logic [LIMIT_BITS-1:0] trace_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_en_ff    <= 1'b0;
         trace_limit_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_TRACE_ENABLE) begin
            trace_en_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_TRACE_LIMIT) begin
            trace_limit_ff <= csr_wdata;
         end
      end
   end

   // item registers
   logic [1:0]             item_op_ff;
   logic [ANCHOR_BITS-1:0] item_anchor_ff;
   logic [TIME_BITS-1:0]   item_ts_ff;
   logic [EW-1:0]          item_anchor_wide;

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_op_ff     <= req_operation;
         item_anchor_ff <= req_anchor;
         item_ts_ff     <= req_timestamp;
      end
   end

   assign item_anchor_wide = EW'(item_anchor_ff);

   // nesting stack
   frame_type           stk_mem [NEST_DEPTH];
   frame_type           stk_rdata_ff;
   logic [DW-1:0]       depth_ff;
   logic [DW-1:0]       depth_in;
   logic [DW-1:0]       depth_dec;
   logic                stk_full;
   logic                push;
   logic [SW-1:0]       stk_raddr;

   assign stk_full  = (depth_ff == DW'(NEST_DEPTH));
   assign push      = cmd.read_issue && (item_op_ff == OP_ENTER) && !stk_full;
   assign depth_dec = depth_ff - 1'b1;
   assign stk_raddr = depth_dec[SW-1:0];

   always_comb begin
      depth_in = depth_ff;
      if (push) begin
         depth_in = depth_ff + 1'b1;
      end else if (cmd.pop_issue) begin
         depth_in = depth_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stk_mem[depth_ff[SW-1:0]] <= '{anchor: item_anchor_ff, start: item_ts_ff};
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   // totals memory
   totals_type    tbl_mem [ANCHORS];
   totals_type    tbl_rdata_ff;
   totals_type    tbl_wdata;
   totals_type    acc_new;
   logic [AW-1:0] tbl_raddr;
   logic [AW-1:0] tbl_waddr;
   logic          tbl_we;
   logic [AW-1:0] clr_addr_ff;
   logic [EW-1:0] stk_anchor_wide;

   logic [AW-1:0]          a_ff;
   logic [AW-1:0]          parent_ff;
   logic [TIME_BITS-1:0]   start_ff;
   logic [TIME_BITS-1:0]   elapsed_ff;
   logic [TIME_BITS:0]     diff;
   logic [TIME_BITS-1:0]   parent_excl;

   assign stk_anchor_wide = EW'(stk_rdata_ff.anchor);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign acc_new.exclusive = tbl_rdata_ff.exclusive + elapsed_ff;
   assign acc_new.inclusive = tbl_rdata_ff.inclusive + elapsed_ff;
   assign acc_new.calls     = tbl_rdata_ff.calls + 1'b1;
   assign parent_excl       = tbl_rdata_ff.exclusive - elapsed_ff;

   always_comb begin
      priority if (cmd.read_issue) begin
         tbl_raddr = item_anchor_wide[AW-1:0];
      end else if (cmd.pop_capture) begin
         tbl_raddr = stk_anchor_wide[AW-1:0];
      end else if (cmd.parent_issue) begin
         tbl_raddr = parent_ff;
      end else begin
         tbl_raddr = '0;
      end
   end

   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = clr_addr_ff;
      tbl_wdata = '0;
      priority if (cmd.clear_step) begin
         tbl_we = 1'b1;
      end else if (cmd.acc_update) begin
         tbl_we    = 1'b1;
         tbl_waddr = a_ff;
         tbl_wdata = acc_new;
      end else if (cmd.parent_update) begin
         tbl_we    = 1'b1;
         tbl_waddr = parent_ff;
         tbl_wdata = '{exclusive: parent_excl,
                       inclusive: tbl_rdata_ff.inclusive,
                       calls:     tbl_rdata_ff.calls};
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rdata_ff <= tbl_mem[tbl_raddr];
   end

   // popped frame
   assign diff = {1'b0, item_ts_ff} - {1'b0, stk_rdata_ff.start};

   always_ff @(posedge clock) begin
      if (cmd.pop_capture) begin
         a_ff        <= stk_anchor_wide[AW-1:0];
         start_ff    <= stk_rdata_ff.start;
         elapsed_ff  <= diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
      end
      if (cmd.acc_update) begin
         parent_ff <= stk_anchor_wide[AW-1:0];
      end
   end

   // trace budget
   logic trace_fire;

   assign trace_fire = trace_en_ff && (trace_count_ff < trace_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_count_ff <= '0;
      end else if (cmd.acc_update && trace_fire) begin
         trace_count_ff <= trace_count_ff + 1'b1;
      end
   end

   // result assembly
   status_type             res_status_ff;
   logic [ANCHOR_BITS-1:0] res_anchor_ff;
   totals_type             res_totals_ff;
   logic                   res_trace_valid_ff;
   logic [TIME_BITS-1:0]   res_trace_start_ff;
   logic [TIME_BITS-1:0]   res_trace_dur_ff;

   always_ff @(posedge clock) begin
      if (cmd.fail_empty || cmd.fail_anchor || cmd.read_issue || cmd.pop_capture) begin
         res_totals_ff      <= '0;
         res_trace_valid_ff <= 1'b0;
         res_trace_start_ff <= '0;
         res_trace_dur_ff   <= '0;
      end
      if (cmd.fail_empty) begin
         res_status_ff <= STATUS_EMPTY;
         res_anchor_ff <= '0;
      end
      if (cmd.fail_anchor) begin
         res_status_ff <= STATUS_ANCHOR;
         res_anchor_ff <= item_anchor_ff;
      end
      if (cmd.read_issue) begin
         res_status_ff <= (item_op_ff == OP_ENTER && stk_full) ? STATUS_FULL : STATUS_OK;
         res_anchor_ff <= item_anchor_ff;
      end
      if (cmd.capture_totals) begin
         res_totals_ff <= tbl_rdata_ff;
      end
      if (cmd.pop_capture) begin
         res_status_ff <= STATUS_OK;
         res_anchor_ff <= stk_rdata_ff.anchor;
      end
      if (cmd.acc_update) begin
         res_totals_ff <= acc_new;
         if (trace_fire) begin
            res_trace_valid_ff <= 1'b1;
            res_trace_start_ff <= start_ff;
            res_trace_dur_ff   <= elapsed_ff;
         end
      end
      if (cmd.parent_update && parent_ff == a_ff) begin
         res_totals_ff.exclusive <= parent_excl;
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status          <= res_status_ff;
         rsp_result_anchor   <= res_anchor_ff;
         rsp_exclusive_total <= res_totals_ff.exclusive;
         rsp_inclusive_total <= res_totals_ff.inclusive;
         rsp_call_count      <= res_totals_ff.calls;
         rsp_trace_valid     <= res_trace_valid_ff;
         rsp_trace_start     <= res_trace_start_ff;
         rsp_trace_duration  <= res_trace_dur_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign stat.op_exit    = (item_op_ff == OP_EXIT);
   assign stat.anchor_bad = (item_anchor_ff == '0) ||
                            ({1'b0, item_anchor_wide} >= (EW+1)'(ANCHORS));
   assign stat.depth_zero = (depth_ff == '0);
   assign stat.clear_last = (clr_addr_ff == AW'(ANCHORS - 1));
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

endmodule
`default_nettype wire

// ----- hdl/nested_scope_time_accumulator.sv -----
// Error results go straight to the response; enter and read fetch the anchor's totals; exit
// pops a frame, updates its anchor's totals and, unless outermost, the parent's exclusive time,
//   by read-modify-write on the totals memory; req_stall is high until the result is loaded.
// Reset: synchronous, active high; clears control state, then zeros the totals
//   memory one entry a cycle with req_stall high.
`default_nettype none
module nested_scope_time_accumulator
   import nsta_pkg::*;
#(
   parameter int ANCHORS    = 256,
   parameter int NEST_DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_operation,
   input  wire logic [ANCHOR_BITS-1:0]    req_anchor,
   input  wire logic [TIME_BITS-1:0]      req_timestamp,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [ANCHOR_BITS-1:0]         rsp_result_anchor,
   output logic [TIME_BITS-1:0]           rsp_exclusive_total,
   output logic [TIME_BITS-1:0]           rsp_inclusive_total,
   output logic [CALL_BITS-1:0]           rsp_call_count,
   output logic                           rsp_trace_valid,
   output logic [TIME_BITS-1:0]           rsp_trace_start,
   output logic [TIME_BITS-1:0]           rsp_trace_duration,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [LIMIT_BITS-1:0]     csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign req_stall = !cmd.ready;
   assign csr_ready = 1'b1;

   nsta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   nsta_datapath #(
      .ANCHORS    (ANCHORS),
      .NEST_DEPTH (NEST_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_anchor          (req_anchor),
      .req_timestamp       (req_timestamp),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_result_anchor   (rsp_result_anchor),
      .rsp_exclusive_total (rsp_exclusive_total),
      .rsp_inclusive_total (rsp_inclusive_total),
      .rsp_call_count      (rsp_call_count),
      .rsp_trace_valid     (rsp_trace_valid),
      .rsp_trace_start     (rsp_trace_start),
      .rsp_trace_duration  (rsp_trace_duration)
   );

endmodule
`default_nettype wire

// ----- hdl/nsta_checker.sv -----
`default_nettype none
`include "nested_scope_time_accumulator_defines.svh"
module nsta_checker
   import nsta_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [1:0]             rsp_status,
   input wire logic [ANCHOR_BITS-1:0] rsp_result_anchor,
   input wire logic [TIME_BITS-1:0]   rsp_exclusive_total,
   input wire logic [TIME_BITS-1:0]   rsp_inclusive_total,
   input wire logic [CALL_BITS-1:0]   rsp_call_count,
   input wire logic                   rsp_trace_valid
);

   `NSTA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_call_count))

   `NSTA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   `NSTA_ASSERT_NOW(a_empty_exit_zero, clock, reset,
      rsp_valid && rsp_status == STATUS_EMPTY,
      rsp_result_anchor == '0 && rsp_call_count == '0 && rsp_inclusive_total == '0)

   `NSTA_ASSERT_NOW(a_trace_only_ok, clock, reset,
      rsp_valid && rsp_trace_valid,
      rsp_status == STATUS_OK)

   `NSTA_ASSERT_NOW(a_bad_anchor_zero, clock, reset,
      rsp_valid && rsp_status == STATUS_ANCHOR,
      rsp_exclusive_total == '0 && !rsp_trace_valid)

endmodule

bind nested_scope_time_accumulator nsta_checker u_nsta_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_result_anchor   (rsp_result_anchor),
   .rsp_exclusive_total (rsp_exclusive_total),
   .rsp_inclusive_total (rsp_inclusive_total),
   .rsp_call_count      (rsp_call_count),
   .rsp_trace_valid     (rsp_trace_valid)
);
`default_nettype wire
